// ===== hdl/ets_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ets_pkg
// Shared types and codes of the EEPROM transfer segmenter.
// ---------------------------------------------------------------------------
package ets_pkg;

    // Request and segment kinds.
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    // Control byte of chip zero.
    localparam logic [7:0] CTRL_BASE = 8'hA0;

    // Field widths fixed by the interface.
    localparam int KIND_W = 2;
    localparam int ADDR_W = 18;
    localparam int LEN_W  = 13;
    localparam int OFF_W  = 16;
    localparam int BUF_W  = 12;
    localparam int CHIP_W = 2;
    // Page room needs to hold the largest supported page size.
    localparam int ROOM_W = 10;

    // A request never yields more results than this.
    localparam int MAX_RESULTS = 33;
    localparam int CNT_W       = 6;

    // One classified request, handed from the front part to the back part.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [1:0]        status;
        logic [CHIP_W-1:0] chip;
        logic [OFF_W-1:0]  off;
        logic [ROOM_W-1:0] room;
        logic [LEN_W-1:0]  len;
    } t_job;

endpackage

// ===== hdl/eeprom_transfer_segmenter_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eeprom_transfer_segmenter_top
// Splits a transfer request on a bank of serial EEPROMs into page- and
// chip-bounded bus segments.
//
//   Channel   Direction  Handshake            Word
//   request   in         i_valid / o_stall    i_req_type, i_start_addr, i_length
//   segment   out        o_valid / i_stall    o_seg_kind ... o_last
//
// The front part takes a request, works out the page remainder in its
// states F_QUOT, F_PROD and F_REM (reciprocal multiply, product,
// correction) and queues it in F_PUSH, where a full queue holds it. The back
// part loads a job and emits one segment word per cycle while the output
// is not stalled, up to 33 per request, as the front prepares the next one.
// A request of type three is taken and dropped. Reset is synchronous and
// clears the control state only. An output stall holds the back part.
// ---------------------------------------------------------------------------
module eeprom_transfer_segmenter_top #(
    parameter int PAGE_BYTES = 128,
    parameter int CHIP_BYTES = 65536,
    parameter int CHIP_COUNT = 4,
    parameter int MAX_LEN    = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [17:0] i_start_addr,
    input  logic [12:0] i_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_seg_kind,
    output logic [7:0]  o_device_code,
    output logic [15:0] o_chip_offset,
    output logic [12:0] o_seg_len,
    output logic [11:0] o_buf_offset,
    output logic [1:0]  o_status,
    output logic        o_last
);

    ets_pkg::t_job w_push_job;
    ets_pkg::t_job w_pop_job;
    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;

    ets_front #(
        .PAGE_BYTES (PAGE_BYTES),
        .CHIP_BYTES (CHIP_BYTES),
        .CHIP_COUNT (CHIP_COUNT),
        .MAX_LEN    (MAX_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_start_addr (i_start_addr),
        .i_length     (i_length),
        .o_push       (w_push),
        .i_full       (w_full),
        .o_job        (w_push_job)
    );

    ets_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_pop_job)
    );

    ets_back #(
        .PAGE_BYTES (PAGE_BYTES),
        .CHIP_BYTES (CHIP_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .i_job         (w_pop_job),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_seg_kind    (o_seg_kind),
        .o_device_code (o_device_code),
        .o_chip_offset (o_chip_offset),
        .o_seg_len     (o_seg_len),
        .o_buf_offset  (o_buf_offset),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule

// ===== hdl/ets_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ets_front
// Accepts requests, checks them, finds chip and chip offset, and works out
// the room left in the first page before pushing a job into the queue.
// ---------------------------------------------------------------------------
module ets_front #(
    parameter int PAGE_BYTES = 128,
    parameter int CHIP_BYTES = 65536,
    parameter int CHIP_COUNT = 4,
    parameter int MAX_LEN    = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ets_pkg::KIND_W-1:0]  i_req_type,
    input  logic [ets_pkg::ADDR_W-1:0]  i_start_addr,
    input  logic [ets_pkg::LEN_W-1:0]   i_length,
    output logic                        o_push,
    input  logic                        i_full,
    output ets_pkg::t_job               o_job
);

    localparam int SPACE = CHIP_BYTES * CHIP_COUNT;
    // Reciprocal of the page size for the page remainder of the offset.
    localparam logic [13:0] RECIP = 14'((1 << 16) / PAGE_BYTES);
    localparam logic [9:0]  PAGE  = 10'(PAGE_BYTES);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_QUOT = 5'b00010,
        F_PROD = 5'b00100,
        F_REM  = 5'b01000,
        F_PUSH = 5'b10000
    } t_fstate;

    t_fstate r_state, n_state;

    logic [ets_pkg::KIND_W-1:0] r_kind;
    logic [1:0]                 r_status;
    logic [ets_pkg::LEN_W-1:0]  r_len;
    logic [ets_pkg::CHIP_W-1:0] r_chip;
    logic [ets_pkg::OFF_W-1:0]  r_off;
    logic [13:0]                r_quot;
    logic [16:0]                r_prod;
    logic [ets_pkg::ROOM_W-1:0] r_room;

    logic                       w_accept;
    logic [19:0]                w_addr;
    logic [19:0]                w_end;
    logic                       w_zero;
    logic                       w_range;
    logic [ets_pkg::CHIP_W-1:0] w_chip;
    logic [19:0]                w_base;
    logic [19:0]                w_off_full;
    logic [29:0]                w_qprod;
    logic [23:0]                w_pprod;
    logic [16:0]                w_r;
    logic [16:0]                w_r2;

    assign o_stall  = (r_state != F_IDLE);
    assign w_accept = i_valid && (r_state == F_IDLE);

    always_comb begin
        w_addr  = {2'b00, i_start_addr};
        w_end   = w_addr + {7'b0, i_length};
        w_zero  = (i_length == '0);
        w_range = ({4'b0, i_length} > 17'(MAX_LEN)) || (w_end > 20'(SPACE));
        if (w_addr >= 20'(3 * CHIP_BYTES)) begin
            w_chip = 2'd3;
        end else if (w_addr >= 20'(2 * CHIP_BYTES)) begin
            w_chip = 2'd2;
        end else if (w_addr >= 20'(CHIP_BYTES)) begin
            w_chip = 2'd1;
        end else begin
            w_chip = 2'd0;
        end
        unique case (w_chip)
            2'd0:    w_base = 20'd0;
            2'd1:    w_base = 20'(CHIP_BYTES);
            2'd2:    w_base = 20'(2 * CHIP_BYTES);
            default: w_base = 20'(3 * CHIP_BYTES);
        endcase
        w_off_full = w_addr - w_base;
        // The quotient may come out one short; the remainder step fixes that.
        w_qprod = {14'b0, r_off} * {16'b0, RECIP};
        w_pprod = {10'b0, r_quot} * {14'b0, PAGE};
        w_r     = {1'b0, r_off} - r_prod;
        w_r2    = (w_r >= {7'b0, PAGE}) ? (w_r - {7'b0, PAGE}) : w_r;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept && (i_req_type != ets_pkg::KIND_NONE)) begin
                    n_state = F_QUOT;
                end
            end
            F_QUOT:  n_state = F_PROD;
            F_PROD:  n_state = F_REM;
            F_REM:   n_state = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_req_type;
            r_len  <= i_length;
            r_chip <= w_chip;
            r_off  <= w_off_full[ets_pkg::OFF_W-1:0];
            if (w_zero) begin
                r_status <= ets_pkg::ST_ZERO;
            end else if (w_range) begin
                r_status <= ets_pkg::ST_RANGE;
            end else begin
                r_status <= ets_pkg::ST_OK;
            end
        end
        if (r_state == F_QUOT) begin
            r_quot <= w_qprod[29:16];
        end
        if (r_state == F_PROD) begin
            r_prod <= w_pprod[16:0];
        end
        if (r_state == F_REM) begin
            r_room <= PAGE - w_r2[ets_pkg::ROOM_W-1:0];
        end
    end

    assign o_push      = (r_state == F_PUSH) && !i_full;
    assign o_job.kind   = r_kind;
    assign o_job.status = r_status;
    assign o_job.chip   = r_chip;
    assign o_job.off    = r_off;
    assign o_job.room   = r_room;
    assign o_job.len    = r_len;

endmodule

// ===== hdl/ets_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ets_queue
// Two-entry job queue between the front part and the back part.
// ---------------------------------------------------------------------------
module ets_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ets_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ets_pkg::t_job o_job
);

    ets_pkg::t_job r_slot [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

endmodule

// ===== hdl/ets_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ets_back
// Takes a job from the queue and steps through its segments, one result
// word per cycle while the output is not stalled, into the output register.
// ---------------------------------------------------------------------------
module ets_back #(
    parameter int PAGE_BYTES = 128,
    parameter int CHIP_BYTES = 65536
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  ets_pkg::t_job               i_job,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ets_pkg::KIND_W-1:0]  o_seg_kind,
    output logic [7:0]                  o_device_code,
    output logic [ets_pkg::OFF_W-1:0]   o_chip_offset,
    output logic [ets_pkg::LEN_W-1:0]   o_seg_len,
    output logic [ets_pkg::BUF_W-1:0]   o_buf_offset,
    output logic [1:0]                  o_status,
    output logic                        o_last
);

    localparam logic [ets_pkg::ROOM_W-1:0] PAGE = ets_pkg::ROOM_W'(PAGE_BYTES);

    logic                        r_active;
    logic                        r_out_valid;
    logic [ets_pkg::CNT_W-1:0]   r_k;
    logic [ets_pkg::KIND_W-1:0]  r_kind;
    logic [1:0]                  r_status;
    logic [ets_pkg::CHIP_W-1:0]  r_chip;
    logic [ets_pkg::OFF_W-1:0]   r_off;
    logic [ets_pkg::ROOM_W-1:0]  r_room;
    logic [ets_pkg::LEN_W-1:0]   r_rem;
    logic [ets_pkg::BUF_W-1:0]   r_buf;

    logic                        w_emit;
    logic                        w_read;
    logic                        w_err;
    logic [16:0]                 w_chip_left;
    logic [16:0]                 w_room17;
    logic [16:0]                 w_cand;
    logic                        w_fin_len;
    logic [ets_pkg::LEN_W-1:0]   w_seg;
    logic                        w_last;
    logic [16:0]                 n_off;
    logic                        w_wrap;
    logic [ets_pkg::ROOM_W-1:0]  w_room_left;
    logic [7:0]                  w_dev;

    // The output register can take a new word when it is empty or drains now.
    assign w_emit = !r_out_valid || !i_stall;
    assign o_pop  = !r_active && !i_empty;
    assign w_read = (r_kind == ets_pkg::KIND_READ);
    assign w_err  = (r_status != ets_pkg::ST_OK);

    always_comb begin
        w_chip_left = 17'(CHIP_BYTES) - {1'b0, r_off};
        w_room17    = {7'b0, r_room};
        if (w_read || (w_chip_left <= w_room17)) begin
            w_cand = w_chip_left;
        end else begin
            w_cand = w_room17;
        end
        w_fin_len   = ({4'b0, r_rem} <= w_cand);
        w_seg       = w_fin_len ? r_rem : w_cand[ets_pkg::LEN_W-1:0];
        w_last      = w_fin_len || (r_k == ets_pkg::CNT_W'(ets_pkg::MAX_RESULTS - 1));
        n_off       = {1'b0, r_off} + {4'b0, w_seg};
        w_wrap      = (n_off == 17'(CHIP_BYTES));
        // Page room is only meaningful for writes and fills, where the
        // segment never exceeds it.
        w_room_left = r_room - w_seg[ets_pkg::ROOM_W-1:0];
        w_dev       = ets_pkg::CTRL_BASE + {5'b0, r_chip, 1'b0} + {7'b0, w_read};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (r_active && w_emit && (w_err || w_last)) begin
                r_active <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= r_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_k      <= '0;
            r_kind   <= i_job.kind;
            r_status <= i_job.status;
            r_chip   <= i_job.chip;
            r_off    <= i_job.off;
            r_room   <= i_job.room;
            r_rem    <= i_job.len;
            r_buf    <= '0;
        end else if (r_active && w_emit) begin
            r_k   <= r_k + ets_pkg::CNT_W'(1);
            r_rem <= r_rem - w_seg;
            r_buf <= r_buf + w_seg[ets_pkg::BUF_W-1:0];
            if (w_wrap) begin
                r_off  <= '0;
                r_chip <= r_chip + ets_pkg::CHIP_W'(1);
                r_room <= PAGE;
            end else begin
                r_off  <= n_off[ets_pkg::OFF_W-1:0];
                r_room <= (w_room_left == '0) ? PAGE : w_room_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active && w_emit) begin
            o_seg_kind <= r_kind;
            o_status   <= r_status;
            if (w_err) begin
                o_device_code <= '0;
                o_chip_offset <= '0;
                o_seg_len     <= '0;
                o_buf_offset  <= '0;
                o_last        <= 1'b1;
            end else begin
                o_device_code <= w_dev;
                o_chip_offset <= r_off;
                o_seg_len     <= w_seg;
                o_buf_offset  <= r_buf;
                o_last        <= w_last;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== test/eeprom_transfer_segmenter_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eeprom_transfer_segmenter_checker
// Watches the request and segment channels of the transfer segmenter. Every
// request taken is split into the segment words it should produce; every
// segment word taken is compared field by field with the oldest one waiting.
// ---------------------------------------------------------------------------
module eeprom_transfer_segmenter_checker #(
    parameter int PAGE_BYTES = 128,
    parameter int CHIP_BYTES = 65536,
    parameter int CHIP_COUNT = 4,
    parameter int MAX_LEN    = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [1:0]  i_req_type,
    input  logic [17:0] i_start_addr,
    input  logic [12:0] i_length,
    input  logic        i_seg_valid,
    input  logic        i_seg_stall,
    input  logic [1:0]  i_seg_kind,
    input  logic [7:0]  i_device_code,
    input  logic [15:0] i_chip_offset,
    input  logic [12:0] i_seg_len,
    input  logic [11:0] i_buf_offset,
    input  logic [1:0]  i_status,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned SPACE = CHIP_BYTES * CHIP_COUNT;

    typedef struct packed {
        logic [1:0]  seg_kind;
        logic [7:0]  device_code;
        logic [15:0] chip_offset;
        logic [12:0] seg_len;
        logic [11:0] buf_offset;
        logic [1:0]  status;
        logic        last;
    } t_seg_word;

    t_seg_word segments_due[$];
    int        fail_count    = 0;
    int        pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // Queues the segment words that one request should produce.
    function automatic void plan_segments(input logic [1:0] kind, input logic [17:0] addr,
                                          input logic [12:0] len);
        int unsigned pos;
        int unsigned remaining;
        int unsigned buf_pos;
        int unsigned off;
        int unsigned room;
        int unsigned take;
        int unsigned dev;
        int          count;
        t_seg_word   w;
        if (kind == ets_pkg::KIND_NONE) begin
            return;
        end
        w          = '0;
        w.seg_kind = kind;
        w.last     = 1'b1;
        pos        = addr;
        remaining  = len;
        // A zero length is reported even when the address is also out of range.
        if (remaining == 0) begin
            w.status = ets_pkg::ST_ZERO;
            segments_due.push_back(w);
            return;
        end
        if (remaining > MAX_LEN || pos + remaining > SPACE) begin
            w.status = ets_pkg::ST_RANGE;
            segments_due.push_back(w);
            return;
        end
        buf_pos = 0;
        count   = 0;
        while (remaining > 0 && count < ets_pkg::MAX_RESULTS) begin
            off  = pos % CHIP_BYTES;
            take = CHIP_BYTES - off;
            // Reads run on to the chip boundary; writes and fills stop at each page.
            if (kind != ets_pkg::KIND_READ) begin
                room = PAGE_BYTES - off % PAGE_BYTES;
                if (room < take) begin
                    take = room;
                end
            end
            if (remaining < take) begin
                take = remaining;
            end
            dev = ets_pkg::CTRL_BASE + 2 * (pos / CHIP_BYTES)
                + ((kind == ets_pkg::KIND_READ) ? 1 : 0);
            w.device_code = 8'(dev);
            w.chip_offset = 16'(off);
            w.seg_len     = 13'(take);
            w.buf_offset  = 12'(buf_pos);
            w.status      = ets_pkg::ST_OK;
            w.last        = (take == remaining) || (count == ets_pkg::MAX_RESULTS - 1);
            segments_due.push_back(w);
            count++;
            pos       += take;
            buf_pos   += take;
            remaining -= take;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_seg_word want;
        if (i_rst_n) begin
            if (i_req_valid && !i_req_stall) begin
                plan_segments(i_req_type, i_start_addr, i_length);
            end
            if (i_seg_valid && !i_seg_stall) begin
                if (segments_due.size() == 0) begin
                    $error("segment word with nothing expected: kind %0d device %0h len %0d",
                           i_seg_kind, i_device_code, i_seg_len);
                    fail_count++;
                end else begin
                    want = segments_due.pop_front();
                    check_field("seg_kind", want.seg_kind, i_seg_kind);
                    check_field("device_code", want.device_code, i_device_code);
                    check_field("chip_offset", want.chip_offset, i_chip_offset);
                    check_field("seg_len", want.seg_len, i_seg_len);
                    check_field("buf_offset", want.buf_offset, i_buf_offset);
                    check_field("status", want.status, i_status);
                    check_field("last", want.last, i_last);
                end
            end
            pending_count = segments_due.size();
        end
    end

endmodule

// ===== test/eeprom_transfer_segmenter_top_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eeprom_transfer_segmenter_top_test
// Drives transfer requests into the segmenter, first a directed set of edge
// cases and then random requests in bursts, while the segment side stalls in
// changing patterns. The checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module eeprom_transfer_segmenter_top_test;

    localparam int RANDOM_REQUESTS = 200;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int TAIL_CYCLES     = 80;

    typedef enum int {
        FLOW_FREE,
        FLOW_LIGHT,
        FLOW_HEAVY,
        FLOW_PERIODIC
    } t_flow_mode;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [1:0]  i_req_type   = ets_pkg::KIND_WRITE;
    logic [17:0] i_start_addr = '0;
    logic [12:0] i_length     = '0;
    logic        i_stall      = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_seg_kind;
    logic [7:0]  o_device_code;
    logic [15:0] o_chip_offset;
    logic [12:0] o_seg_len;
    logic [11:0] o_buf_offset;
    logic [1:0]  o_status;
    logic        o_last;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          burst_left  = 0;
    t_flow_mode  flow_mode   = FLOW_FREE;
    int          flow_left   = 0;
    int          flow_phase  = 0;

    eeprom_transfer_segmenter_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_start_addr (i_start_addr),
        .i_length     (i_length),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_seg_kind   (o_seg_kind),
        .o_device_code(o_device_code),
        .o_chip_offset(o_chip_offset),
        .o_seg_len    (o_seg_len),
        .o_buf_offset (o_buf_offset),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    eeprom_transfer_segmenter_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_req_type   (i_req_type),
        .i_start_addr (i_start_addr),
        .i_length     (i_length),
        .i_seg_valid  (o_valid),
        .i_seg_stall  (i_stall),
        .i_seg_kind   (o_seg_kind),
        .i_device_code(o_device_code),
        .i_chip_offset(o_chip_offset),
        .i_seg_len    (o_seg_len),
        .i_buf_offset (o_buf_offset),
        .i_status     (o_status),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("eeprom_transfer_segmenter_top_test: errors");
            $finish;
        end
    end

    // The segment side switches between randomly chosen stall patterns.
    always @(negedge i_clk) begin
        if (flow_left == 0) begin
            flow_mode <= t_flow_mode'($urandom_range(0, 3));
            flow_left <= $urandom_range(20, 120);
            i_stall   <= 1'b0;
        end else begin
            flow_left  <= flow_left - 1;
            flow_phase <= flow_phase + 1;
            case (flow_mode)
                FLOW_FREE:     i_stall <= 1'b0;
                FLOW_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                FLOW_HEAVY:    i_stall <= ($urandom_range(0, 1) == 0);
                FLOW_PERIODIC: i_stall <= (flow_phase % 5 < 2);
                default:       i_stall <= 1'b0;
            endcase
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_request(input logic [1:0] kind, input logic [17:0] addr,
                                input logic [12:0] len);
        int gap;
        bit taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
            if (gap != 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid      = 1'b1;
        i_req_type   = kind;
        i_start_addr = addr;
        i_length     = len;
        taken        = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_stall;
            @(negedge i_clk);
        end
    endtask

    // Holds the request side quiet until every expected segment has come out.
    task automatic drain_segments;
        i_valid    = 1'b0;
        burst_left = 0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
    endtask

    initial begin : stimulus
        int          sent;
        int          pick;
        logic [1:0]  kind;
        logic [17:0] addr;
        logic [12:0] len;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed requests: page and chip crossings, the end of the space,
        // both error kinds and the unused request type.
        send_request(ets_pkg::KIND_WRITE, 18'd0, 13'd1);
        send_request(ets_pkg::KIND_WRITE, 18'd5, 13'd4096);
        send_request(ets_pkg::KIND_FILL, 18'd0, 13'd4096);
        send_request(ets_pkg::KIND_FILL, 18'd65472, 13'd200);
        send_request(ets_pkg::KIND_READ, 18'd65530, 13'd20);
        send_request(ets_pkg::KIND_READ, 18'd0, 13'd4096);
        send_request(ets_pkg::KIND_READ, 18'd196600, 13'd100);
        send_request(ets_pkg::KIND_FILL, 18'd131071, 13'd2);
        send_request(ets_pkg::KIND_READ, 18'd262143, 13'd1);
        send_request(ets_pkg::KIND_WRITE, 18'd262143, 13'd1);
        send_request(ets_pkg::KIND_WRITE, 18'd258048, 13'd4096);
        send_request(ets_pkg::KIND_READ, 18'd258048, 13'd4096);
        send_request(ets_pkg::KIND_READ, 18'd262143, 13'd2);
        send_request(ets_pkg::KIND_WRITE, 18'd258049, 13'd4096);
        send_request(ets_pkg::KIND_WRITE, 18'd0, 13'd0);
        send_request(ets_pkg::KIND_FILL, 18'd262143, 13'd0);
        send_request(ets_pkg::KIND_READ, 18'd0, 13'd4097);
        send_request(ets_pkg::KIND_FILL, 18'd100, 13'd8191);
        send_request(ets_pkg::KIND_NONE, 18'd1000, 13'd5);
        send_request(ets_pkg::KIND_NONE, 18'd262143, 13'd0);
        send_request(ets_pkg::KIND_WRITE, 18'd127, 13'd2);
        send_request(ets_pkg::KIND_READ, 18'd131000, 13'd4096);
        drain_segments();

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 99);
            kind = (pick < 3) ? ets_pkg::KIND_NONE : 2'($urandom_range(0, 2));

            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                len = '0;
            end else if (pick < 7) begin
                len = 13'($urandom_range(4097, 8191));
            end else if (pick < 15) begin
                len = 13'($urandom_range(1, 4096));
            end else if (pick < 20) begin
                len = 13'd4096;
            end else begin
                len = 13'($urandom_range(1, 300));
            end

            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                addr = 18'(($urandom_range(1, 3) << 16) - $urandom_range(1, 300));
            end else if (pick < 25) begin
                addr = 18'(262144 - $urandom_range(1, 4200));
            end else begin
                addr = 18'($urandom_range(0, 262143));
            end

            send_request(kind, addr, len);
            if (kind != ets_pkg::KIND_NONE) begin
                sent++;
            end
            if (sent % 70 == 69 && kind != ets_pkg::KIND_NONE) begin
                drain_segments();
            end
        end

        i_valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("eeprom_transfer_segmenter_top_test: clean");
        end else begin
            $display("eeprom_transfer_segmenter_top_test: errors");
        end
        $finish;
    end

endmodule
